@@ sv/lrbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrbc_pkg: shared types and constants for the link retry controller
// Holds the poll and result item layouts, the register map, the reset
// values of the configuration registers and the backoff table helper.
// ----------------------------------------------------------------------------
package lrbc_pkg;

	// Field widths.
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned REG_W      = 24;
	localparam int unsigned FAIL_W     = 8;
	localparam int unsigned UPTIME_W   = 23;
	localparam int unsigned REG_IDX_W  = 3;

	// Number of entries in the backoff delay table.
	localparam int unsigned BACKOFF_ENTRIES = 6;
	localparam int unsigned BACKOFF_IDX_W   = $clog2(BACKOFF_ENTRIES);

	// Failure count saturation value.
	localparam logic [FAIL_W-1:0] FAIL_MAX = 8'd255;

	// Division by one thousand: the quotient is (x * UPTIME_RECIP) >> UPTIME_SHIFT,
	// exact for every 32-bit x.
	localparam logic [TIME_W-1:0] UPTIME_RECIP = 32'd2199023256;
	localparam int unsigned       UPTIME_SHIFT = 41;

	// Register map.
	localparam logic [REG_IDX_W-1:0] REG_CONNECT_TIMEOUT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BACKOFF_FIRST   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BACKOFF_SECOND  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BACKOFF_THIRD   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BACKOFF_FOURTH  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BACKOFF_FIFTH   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BACKOFF_LAST    = 3'd6;

	// Register reset values.
	localparam logic [REG_W-1:0] RST_CONNECT_TIMEOUT = 24'd15000;
	localparam logic [REG_W-1:0] RST_BACKOFF_FIRST   = 24'd2000;
	localparam logic [REG_W-1:0] RST_BACKOFF_SECOND  = 24'd5000;
	localparam logic [REG_W-1:0] RST_BACKOFF_THIRD   = 24'd10000;
	localparam logic [REG_W-1:0] RST_BACKOFF_FOURTH  = 24'd20000;
	localparam logic [REG_W-1:0] RST_BACKOFF_FIFTH   = 24'd30000;
	localparam logic [REG_W-1:0] RST_BACKOFF_LAST    = 24'd60000;

	// One poll.
	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              link_up;
	} poll_t;

	// One result.
	typedef struct packed {
		logic                start_attempt;
		logic                cycle_radio;
		logic                link_gained;
		logic                link_lost;
		logic                is_connected;
		logic [FAIL_W-1:0]   failure_count;
		logic [REG_W-1:0]    retry_delay_ms;
		logic [UPTIME_W-1:0] uptime_seconds;
	} result_t;

	// Current configuration as seen by the step logic.
	typedef struct packed {
		logic [REG_W-1:0]                      connect_timeout;
		logic [BACKOFF_ENTRIES-1:0][REG_W-1:0] backoff;
	} cfg_t;

	// Middle stage: the result without uptime, plus the elapsed connected time.
	typedef struct packed {
		result_t           res;
		logic [TIME_W-1:0] up_diff;
		logic              up_valid;
	} stage2_t;

	// Backoff table index: zero for no failures, else failures less one,
	// held at the last entry.
	function automatic logic [BACKOFF_IDX_W-1:0] backoff_idx(input logic [FAIL_W-1:0] fails);
		logic [BACKOFF_IDX_W-1:0] idx;
		if (fails == '0) begin
			idx = '0;
		end else if (fails > FAIL_W'(BACKOFF_ENTRIES)) begin
			idx = BACKOFF_IDX_W'(BACKOFF_ENTRIES - 1);
		end else begin
			idx = BACKOFF_IDX_W'(fails - 8'd1);
		end
		return idx;
	endfunction

endpackage

@@ sv/link_retry_backoff_controller_top.sv @@
// ----------------------------------------------------------------------------
// link_retry_backoff_controller_top: link retry controller with table backoff
// Each poll carries the millisecond time and the link status; each gives one
// result with attempt, radio cycle and link pulses, the failure count, the
// selected retry delay and the uptime in seconds.
//
//   Channel   Handshake                    Payload
//   poll      poll_valid / poll_ready      poll   (now_ms, link_up)
//   result    result_valid / result_ready  result (pulses, counts, uptime)
//   config    cfg_we                       cfg_index, cfg_wdata
//
// One poll is accepted every cycle unless a stalled result fills the pipeline.
// A poll passes the input register, the decision logic into the middle stage
// register, then the divide-by-1000 multiply into the result register.
// Reset clears the retry state and loads the register reset values; the
// block accepts polls from the first cycle after reset.
// A stalled result holds the pipeline behind it; polls keep flowing while
// any stage is free.
// ----------------------------------------------------------------------------
module link_retry_backoff_controller_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           poll_valid,
	output logic                           poll_ready,
	input  lrbc_pkg::poll_t                poll,
	output logic                           result_valid,
	input  logic                           result_ready,
	output lrbc_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [lrbc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [lrbc_pkg::REG_W-1:0]     cfg_wdata
);
	import lrbc_pkg::*;

	cfg_t    cfg;
	logic    s2_valid;
	logic    s2_take;
	stage2_t s2;

	// Configuration registers.
	lrbc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Retry state and decision.
	lrbc_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.poll_valid (poll_valid),
		.poll_ready (poll_ready),
		.poll       (poll),
		.s2_valid   (s2_valid),
		.s2_take    (s2_take),
		.s2         (s2)
	);

	// Uptime division and result register.
	lrbc_uptime u_uptime (
		.clk          (clk),
		.arst_n       (arst_n),
		.s2_valid     (s2_valid),
		.s2_take      (s2_take),
		.s2           (s2),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ sv/lrbc_cfg.sv @@
// ----------------------------------------------------------------------------
// lrbc_cfg: configuration register file
// Seven 24-bit registers written through a plain write port. Writes to an
// index beyond the map are dropped.
// ----------------------------------------------------------------------------
module lrbc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lrbc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [lrbc_pkg::REG_W-1:0]     cfg_wdata,
	output lrbc_pkg::cfg_t                 cfg
);
	import lrbc_pkg::*;

	cfg_t cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_timeout <= RST_CONNECT_TIMEOUT;
			cfg_q.backoff[0]      <= RST_BACKOFF_FIRST;
			cfg_q.backoff[1]      <= RST_BACKOFF_SECOND;
			cfg_q.backoff[2]      <= RST_BACKOFF_THIRD;
			cfg_q.backoff[3]      <= RST_BACKOFF_FOURTH;
			cfg_q.backoff[4]      <= RST_BACKOFF_FIFTH;
			cfg_q.backoff[5]      <= RST_BACKOFF_LAST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONNECT_TIMEOUT: cfg_q.connect_timeout <= cfg_wdata;
				REG_BACKOFF_FIRST:   cfg_q.backoff[0] <= cfg_wdata;
				REG_BACKOFF_SECOND:  cfg_q.backoff[1] <= cfg_wdata;
				REG_BACKOFF_THIRD:   cfg_q.backoff[2] <= cfg_wdata;
				REG_BACKOFF_FOURTH:  cfg_q.backoff[3] <= cfg_wdata;
				REG_BACKOFF_FIFTH:   cfg_q.backoff[4] <= cfg_wdata;
				REG_BACKOFF_LAST:    cfg_q.backoff[5] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/lrbc_step.sv @@
// ----------------------------------------------------------------------------
// lrbc_step: poll input register, controller state and decision logic
// A poll is captured, evaluated against the retry state in one pass and
// handed to the middle stage; the state is updated as the poll moves on.
// ----------------------------------------------------------------------------
module lrbc_step (
	input  logic              clk,
	input  logic              arst_n,
	input  lrbc_pkg::cfg_t    cfg,
	input  logic              poll_valid,
	output logic              poll_ready,
	input  lrbc_pkg::poll_t   poll,
	output logic              s2_valid,
	input  logic              s2_take,
	output lrbc_pkg::stage2_t s2
);
	import lrbc_pkg::*;

	// Input stage.
	logic  v_s1;
	poll_t poll_s1;
	logic  adv_s1;

	// Middle stage.
	logic    v_s2;
	stage2_t data_s2;

	// Controller state.
	logic                started_q;
	logic                was_conn_q;
	logic                active_q;
	logic [FAIL_W-1:0]   fail_q;
	logic [TIME_W-1:0]   att_start_q;
	logic [TIME_W-1:0]   last_fail_q;
	logic [TIME_W-1:0]   conn_time_q;
	logic                conn_valid_q;

	// Next state and pulses.
	logic                started_n;
	logic                was_conn_n;
	logic                active_n;
	logic [FAIL_W-1:0]   fail_n;
	logic [TIME_W-1:0]   att_start_n;
	logic [TIME_W-1:0]   last_fail_n;
	logic [TIME_W-1:0]   conn_time_n;
	logic                conn_valid_n;
	logic                p_start;
	logic                p_cycle;
	logic                p_gain;
	logic                p_lost;

	// Elapsed times and thresholds.
	logic [TIME_W-1:0]   now;
	logic                up;
	logic [TIME_W-1:0]   att_elapsed;
	logic [TIME_W-1:0]   fail_elapsed;
	logic [REG_W-1:0]    delay_cur;
	logic                timed_out;
	logic                backoff_done;
	stage2_t             s2_n;

	// Handshake: the poll leaves the input stage when the middle stage frees up.
	assign adv_s1     = v_s1 && (!v_s2 || s2_take);
	assign poll_ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (poll_ready) begin
			v_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_ready && poll_valid) begin
			poll_s1 <= poll;
		end
	end

	assign now = poll_s1.now_ms;
	assign up  = poll_s1.link_up;

	// The very first poll starts the attempt at this time, so its elapsed time is zero.
	assign att_elapsed  = started_q ? (now - att_start_q) : '0;
	assign fail_elapsed = now - last_fail_q;
	assign delay_cur    = cfg.backoff[backoff_idx(fail_q)];
	assign timed_out    = att_elapsed >= {{(TIME_W-REG_W){1'b0}}, cfg.connect_timeout};
	assign backoff_done = fail_elapsed >= {{(TIME_W-REG_W){1'b0}}, delay_cur};

	// Retry decision for the poll in the input stage.
	always_comb begin
		started_n    = started_q;
		was_conn_n   = was_conn_q;
		active_n     = active_q;
		fail_n       = fail_q;
		att_start_n  = att_start_q;
		last_fail_n  = last_fail_q;
		conn_time_n  = conn_time_q;
		conn_valid_n = conn_valid_q;
		p_start      = 1'b0;
		p_cycle      = 1'b0;
		p_gain       = 1'b0;
		p_lost       = 1'b0;

		if (!started_q) begin
			started_n   = 1'b1;
			active_n    = 1'b1;
			att_start_n = now;
			p_start     = 1'b1;
		end

		if (up) begin
			if (!was_conn_q) begin
				was_conn_n   = 1'b1;
				active_n     = 1'b0;
				fail_n       = '0;
				conn_time_n  = now;
				conn_valid_n = 1'b1;
				p_gain       = 1'b1;
			end
		end else begin
			if (was_conn_q) begin
				was_conn_n   = 1'b0;
				conn_valid_n = 1'b0;
				p_lost       = 1'b1;
			end
			if (active_n) begin
				if (timed_out) begin
					active_n    = 1'b0;
					last_fail_n = now;
					if (fail_q != FAIL_MAX) begin
						fail_n = fail_q + 8'd1;
					end
					p_cycle = 1'b1;
				end
			end else if (backoff_done) begin
				active_n    = 1'b1;
				att_start_n = now;
				p_start     = 1'b1;
			end
		end
	end

	// Result fields, uptime still as a millisecond difference.
	always_comb begin
		s2_n.res.start_attempt  = p_start;
		s2_n.res.cycle_radio    = p_cycle;
		s2_n.res.link_gained    = p_gain;
		s2_n.res.link_lost      = p_lost;
		s2_n.res.is_connected   = up;
		s2_n.res.failure_count  = fail_n;
		s2_n.res.retry_delay_ms = cfg.backoff[backoff_idx(fail_n)];
		s2_n.res.uptime_seconds = '0;
		s2_n.up_diff            = now - conn_time_n;
		s2_n.up_valid           = conn_valid_n;
	end

	// State update as the poll moves to the middle stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			was_conn_q   <= 1'b0;
			active_q     <= 1'b0;
			fail_q       <= '0;
			att_start_q  <= '0;
			last_fail_q  <= '0;
			conn_time_q  <= '0;
			conn_valid_q <= 1'b0;
		end else if (adv_s1) begin
			started_q    <= started_n;
			was_conn_q   <= was_conn_n;
			active_q     <= active_n;
			fail_q       <= fail_n;
			att_start_q  <= att_start_n;
			last_fail_q  <= last_fail_n;
			conn_time_q  <= conn_time_n;
			conn_valid_q <= conn_valid_n;
		end
	end

	// Middle stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || s2_take) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= s2_n;
		end
	end

	assign s2_valid = v_s2;
	assign s2       = data_s2;

endmodule

@@ sv/lrbc_uptime.sv @@
// ----------------------------------------------------------------------------
// lrbc_uptime: uptime in seconds and the result register
// Divides the connected time by one thousand with a reciprocal multiply and
// holds the finished item until it is taken.
// ----------------------------------------------------------------------------
module lrbc_uptime (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s2_valid,
	output logic              s2_take,
	input  lrbc_pkg::stage2_t s2,
	output logic              result_valid,
	input  logic              result_ready,
	output lrbc_pkg::result_t result
);
	import lrbc_pkg::*;

	logic                  v_s3;
	result_t               res_s3;
	result_t               res_n;
	logic [2*TIME_W-1:0]   prod;
	logic [UPTIME_W-1:0]   secs;

	// The middle stage drains whenever the result register is free or being taken.
	assign s2_take = !v_s3 || result_ready;

	// Reciprocal multiply; the quotient is the top bits of the product.
	assign prod = {{TIME_W{1'b0}}, s2.up_diff} * {{TIME_W{1'b0}}, UPTIME_RECIP};
	assign secs = s2.up_valid ? prod[UPTIME_SHIFT +: UPTIME_W] : '0;

	// Finished item: the decision fields with the uptime filled in.
	always_comb begin
		res_n                = s2.res;
		res_n.uptime_seconds = secs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s2_take) begin
			v_s3 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid && s2_take) begin
			res_s3 <= res_n;
		end
	end

	assign result_valid = v_s3;
	assign result       = res_s3;

endmodule

@@ sv/lrbc_checker.sv @@
// ----------------------------------------------------------------------------
// lrbc_checker: port-level checks for the link retry controller
// Watches the result channel for consistency between the pulses, the link
// status, the failure count and the uptime.
// ----------------------------------------------------------------------------
module lrbc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input lrbc_pkg::result_t result
);
	import lrbc_pkg::*;

	// A stalled result item holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result item changed while stalled");

	// A gained link reports connected, with no failures and zero uptime.
	a_gain_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.link_gained |->
			result.is_connected && result.failure_count == '0
			&& result.uptime_seconds == '0)
		else $error("link gained with inconsistent state");

	// A lost link reports disconnected and zero uptime.
	a_loss_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.link_lost |->
			!result.is_connected && !result.link_gained && result.uptime_seconds == '0)
		else $error("link lost with inconsistent state");

	// A timeout only happens while disconnected and always leaves a failure counted.
	a_cycle_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.cycle_radio |->
			!result.is_connected && result.failure_count != '0)
		else $error("radio cycle with inconsistent state");

	// Uptime is only reported while connected.
	a_uptime_conn: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_connected |-> result.uptime_seconds == '0)
		else $error("uptime reported while disconnected");

endmodule

bind link_retry_backoff_controller_top lrbc_checker u_lrbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
